// ===== design/lbrs_pkg.sv =====
package lbrs_pkg;

  localparam int LfsrW     = 34;
  localparam int Slots     = 32;
  localparam int SlotW     = 5;
  localparam int LiveW     = 6;
  localparam int BlockW    = 35;
  localparam int SeedW     = 32;
  localparam int PickW     = 31;
  localparam int MinLen    = 3;
  localparam int CfgW      = 35;
  localparam int RegIdxW   = 1;
  localparam int DivBits   = 8;
  localparam int DividendW = 32;
  localparam int DivSteps  = DividendW / DivBits;
  localparam int CntW      = 5;

  localparam logic [RegIdxW-1:0] RegBlockCount = 1'd0;
  localparam logic [RegIdxW-1:0] RegSeed       = 1'd1;

  typedef enum logic [2:0] {
    StIdle,
    StBuild,
    StDiv,
    StLookup,
    StExec,
    StEmpty
  } lbrs_state_e;

  typedef struct packed {
    logic            load_pick;
    logic            div_step;
    logic            lookup;
    logic            commit;
    logic            emit_empty;
    logic            build_clear;
    logic            build_step;
    logic [CntW-1:0] cnt;
  } lbrs_cmd_t;

  typedef struct packed {
    logic live_zero;
    logic out_free;
  } lbrs_status_t;

  function automatic logic [LfsrW-1:0] tap_mask(input logic [SlotW-1:0] slot);
    logic [LfsrW-1:0] m;
    case (slot)
      5'd0:    m = 34'h6;
      5'd1:    m = 34'hC;
      5'd2:    m = 34'h14;
      5'd3:    m = 34'h2D;
      5'd4:    m = 34'h44;
      5'd5:    m = 34'h8E;
      5'd6:    m = 34'h110;
      5'd7:    m = 34'h204;
      5'd8:    m = 34'h402;
      5'd9:    m = 34'h829;
      5'd10:   m = 34'h1B00;
      5'd11:   m = 34'h3500;
      5'd12:   m = 34'h4001;
      5'd13:   m = 34'h8805;
      5'd14:   m = 34'h10004;
      5'd15:   m = 34'h20040;
      5'd16:   m = 34'h71000;
      5'd17:   m = 34'h80004;
      5'd18:   m = 34'h100002;
      5'd19:   m = 34'h200001;
      5'd20:   m = 34'h400010;
      5'd21:   m = 34'h800043;
      5'd22:   m = 34'h1000004;
      5'd23:   m = 34'h3880000;
      5'd24:   m = 34'h7200000;
      5'd25:   m = 34'h8000004;
      5'd26:   m = 34'h10000002;
      5'd27:   m = 34'h32800000;
      5'd28:   m = 34'h40000004;
      5'd29:   m = 34'hE0000200;
      5'd30:   m = 34'h100001000;
      5'd31:   m = 34'h380000040;
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [LfsrW-1:0] len_mask(input logic [SlotW-1:0] slot);
    logic [LfsrW-1:0] one_hot;
    one_hot = LfsrW'(1) << ({1'b0, slot} + 6'(MinLen));
    return one_hot - LfsrW'(1);
  endfunction

  function automatic logic [BlockW-1:0] base_mask(input logic [SlotW-1:0] slot);
    logic [BlockW-1:0] one_hot;
    one_hot = BlockW'(1) << ({1'b0, slot} + 6'(MinLen));
    return one_hot - BlockW'(1);
  endfunction

endpackage

// ===== design/lbrs_ram.sv =====
module lbrs_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/lbrs_ctrl.sv =====
module lbrs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 cfg_we_i,
  input  lbrs_pkg::lbrs_status_t status_i,
  output lbrs_pkg::lbrs_cmd_t    cmd_o
);

  lbrs_pkg::lbrs_state_e         state_q, state_d;
  logic [lbrs_pkg::CntW-1:0]     cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lbrs_pkg::StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    if (cfg_we_i) begin
      state_d = lbrs_pkg::StBuild;
      cnt_d   = '0;
    end else begin
      case (state_q)
        lbrs_pkg::StIdle: begin
          if (in_valid_i) begin
            state_d = status_i.live_zero ? lbrs_pkg::StEmpty : lbrs_pkg::StDiv;
            cnt_d   = '0;
          end
        end
        lbrs_pkg::StBuild: begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == lbrs_pkg::CntW'(lbrs_pkg::Slots - 1)) begin
            state_d = lbrs_pkg::StIdle;
          end
        end
        lbrs_pkg::StDiv: begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == lbrs_pkg::CntW'(lbrs_pkg::DivSteps - 1)) begin
            state_d = lbrs_pkg::StLookup;
          end
        end
        lbrs_pkg::StLookup: begin
          state_d = lbrs_pkg::StExec;
        end
        lbrs_pkg::StExec, lbrs_pkg::StEmpty: begin
          if (status_i.out_free) begin
            state_d = lbrs_pkg::StIdle;
          end
        end
        default: begin
          state_d = lbrs_pkg::StIdle;
        end
      endcase
    end
  end

  always_comb begin
    in_stall_o        = (state_q != lbrs_pkg::StIdle) || cfg_we_i;
    cmd_o             = '0;
    cmd_o.cnt         = cnt_q;
    cmd_o.build_clear = cfg_we_i;
    if (!cfg_we_i) begin
      case (state_q)
        lbrs_pkg::StIdle:   cmd_o.load_pick  = in_valid_i;
        lbrs_pkg::StBuild:  cmd_o.build_step = 1'b1;
        lbrs_pkg::StDiv:    cmd_o.div_step   = 1'b1;
        lbrs_pkg::StLookup: cmd_o.lookup     = 1'b1;
        lbrs_pkg::StExec:   cmd_o.commit     = status_i.out_free;
        lbrs_pkg::StEmpty:  cmd_o.emit_empty = status_i.out_free;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/lbrs_datapath.sv =====
module lbrs_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lbrs_pkg::lbrs_cmd_t                  cmd_i,
  output lbrs_pkg::lbrs_status_t               status_o,
  input  logic                                 cfg_we_i,
  input  logic [lbrs_pkg::RegIdxW-1:0]         cfg_index_i,
  input  logic [lbrs_pkg::CfgW-1:0]            cfg_wdata_i,
  input  logic [lbrs_pkg::PickW-1:0]           random_pick_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [lbrs_pkg::BlockW-1:0]          block_offset_o,
  output logic                                 range_done_o,
  output logic                                 segment_retired_o
);

  logic [lbrs_pkg::BlockW-1:0]    block_count_q;
  logic [lbrs_pkg::SeedW-1:0]     seed_q;
  logic [lbrs_pkg::LiveW-1:0]     live_q, live_d;
  logic [lbrs_pkg::SlotW-1:0]     list_q [lbrs_pkg::Slots];
  logic [lbrs_pkg::SlotW-1:0]     list_d [lbrs_pkg::Slots];
  logic [lbrs_pkg::DividendW-1:0] dividend_q;
  logic [lbrs_pkg::SlotW-1:0]     rem_q, rem_d;
  logic [lbrs_pkg::SlotW-1:0]     slot_q;
  logic [lbrs_pkg::SlotW-1:0]     pos_q;
  logic                           out_valid_q;
  logic [lbrs_pkg::BlockW-1:0]    offset_q;
  logic                           done_q;
  logic                           retired_q;

  logic [lbrs_pkg::BlockW-1:0]    range_b;
  logic [lbrs_pkg::Slots-1:0]     seg_bits;
  logic [lbrs_pkg::LfsrW-1:0]     cur;
  logic [lbrs_pkg::LfsrW-1:0]     lfsr_next;
  logic [lbrs_pkg::LfsrW-1:0]     seed_m;
  logic [lbrs_pkg::LfsrW-1:0]     build_val;
  logic                           feedback;
  logic                           retire;
  logic [lbrs_pkg::BlockW-1:0]    base;
  logic [lbrs_pkg::BlockW-1:0]    sum;
  logic                           out_free;
  logic                           ram_we;
  logic [lbrs_pkg::SlotW-1:0]     ram_waddr;
  logic [lbrs_pkg::LfsrW-1:0]     ram_wdata;

  assign range_b   = block_count_q & ~lbrs_pkg::BlockW'(7);
  assign seg_bits  = range_b[lbrs_pkg::MinLen +: lbrs_pkg::Slots];
  assign build_val = {{(lbrs_pkg::LfsrW - lbrs_pkg::SeedW){1'b0}}, seed_q}
                   & lbrs_pkg::len_mask(cmd_i.cnt);

  assign feedback  = ^(cur & lbrs_pkg::tap_mask(slot_q));
  assign lfsr_next = ((cur << 1) & lbrs_pkg::len_mask(slot_q))
                   | {{(lbrs_pkg::LfsrW - 1){1'b0}}, feedback};
  assign seed_m    = {{(lbrs_pkg::LfsrW - lbrs_pkg::SeedW){1'b0}}, seed_q}
                   & lbrs_pkg::len_mask(slot_q);
  assign retire    = (lfsr_next == seed_m);
  assign base      = range_b & lbrs_pkg::base_mask(slot_q);
  assign sum       = base + {1'b0, cur};

  assign out_free  = !out_valid_q || !out_stall_i;
  assign status_o.out_free  = out_free;
  assign status_o.live_zero = (live_q == '0);

  assign ram_we    = cmd_i.build_step || cmd_i.commit;
  assign ram_waddr = cmd_i.build_step ? cmd_i.cnt : slot_q;
  assign ram_wdata = cmd_i.build_step ? build_val : lfsr_next;

  lbrs_ram #(
    .Width(lbrs_pkg::LfsrW),
    .Depth(lbrs_pkg::Slots)
  ) u_lfsr_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.lookup),
    .raddr_i(list_q[rem_q]),
    .rdata_o(cur)
  );

  always_comb begin
    logic [lbrs_pkg::SlotW:0] r;
    r = {1'b0, rem_q};
    for (int i = 0; i < lbrs_pkg::DivBits; i++) begin
      r = {r[lbrs_pkg::SlotW-1:0], dividend_q[lbrs_pkg::DividendW-1-i]};
      if (r >= live_q) begin
        r = r - live_q;
      end
    end
    rem_d = r[lbrs_pkg::SlotW-1:0];
  end

  always_comb begin
    list_d = list_q;
    live_d = live_q;
    if (cmd_i.build_clear) begin
      live_d = '0;
    end else if (cmd_i.build_step) begin
      if (seg_bits[cmd_i.cnt]) begin
        list_d[live_q[lbrs_pkg::SlotW-1:0]] = cmd_i.cnt;
        live_d = live_q + 1'b1;
      end
    end else if (cmd_i.commit && retire) begin
      for (int j = 0; j < lbrs_pkg::Slots - 1; j++) begin
        if (lbrs_pkg::SlotW'(j) >= pos_q) begin
          list_d[j] = list_q[j + 1];
        end
      end
      live_d = live_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= '0;
      seed_q        <= '0;
      live_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          lbrs_pkg::RegBlockCount: block_count_q <= cfg_wdata_i;
          lbrs_pkg::RegSeed:       seed_q <= cfg_wdata_i[lbrs_pkg::SeedW-1:0];
          default: ;
        endcase
      end
      live_q <= live_d;
      if (cmd_i.commit || cmd_i.emit_empty) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    list_q <= list_d;
    if (cmd_i.load_pick) begin
      dividend_q <= {1'b0, random_pick_i};
      rem_q      <= '0;
    end else if (cmd_i.div_step) begin
      dividend_q <= dividend_q << lbrs_pkg::DivBits;
      rem_q      <= rem_d;
    end
    if (cmd_i.lookup) begin
      slot_q <= list_q[rem_q];
      pos_q  <= rem_q;
    end
    if (cmd_i.commit) begin
      offset_q  <= retire ? base : sum;
      done_q    <= 1'b0;
      retired_q <= retire;
    end else if (cmd_i.emit_empty) begin
      offset_q  <= '0;
      done_q    <= 1'b1;
      retired_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign block_offset_o    = offset_q;
  assign range_done_o      = done_q;
  assign segment_retired_o = retired_q;

endmodule

// ===== design/lfsr_block_range_shuffler.sv =====
// A request with live segments picks its segment in 8-bit divider steps, then reads
// the segment state from the state RAM and then commits the update to a register.
// Input stays stalled until a request is complete; an empty range skips the divider.
// A configuration write rebuilds the segment list, one segment slot per cycle through
// the state RAM port; input is stalled meanwhile.
// Reset: both registers cleared, no live segments, every request reports range done.
module lfsr_block_range_shuffler (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lbrs_pkg::RegIdxW-1:0]     cfg_index_i,
  input  logic [lbrs_pkg::CfgW-1:0]        cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [lbrs_pkg::PickW-1:0]       random_pick_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [lbrs_pkg::BlockW-1:0]      block_offset_o,
  output logic                             range_done_o,
  output logic                             segment_retired_o
);

  lbrs_pkg::lbrs_cmd_t    cmd;
  lbrs_pkg::lbrs_status_t status;

  lbrs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .cfg_we_i  (cfg_we_i),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  lbrs_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .random_pick_i    (random_pick_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .block_offset_o   (block_offset_o),
    .range_done_o     (range_done_o),
    .segment_retired_o(segment_retired_o)
  );

endmodule
